[sv/isd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package isd_pkg;

  localparam int DEPTH    = 256;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int CNT_W    = PTR_W + 1;
  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int AXES     = 6;
  localparam int SUM_W    = SAMPLE_W + CNT_W;
  localparam int SQ_W     = 2 * SAMPLE_W + CNT_W - 1;
  localparam int VAR_W    = SQ_W + CNT_W + 1;
  localparam int LIM_W    = 32;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 2;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // result codes
  localparam logic [1:0] ST_UNKNOWN    = 2'd0;
  localparam logic [1:0] ST_STATIONARY = 2'd1;
  localparam logic [1:0] ST_MOVING     = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW = 2'd1;
  localparam logic [IDX_W-1:0] REG_GYRO   = 2'd2;
  localparam logic [IDX_W-1:0] REG_ACC    = 2'd3;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SCAN_RD  = 10'b0000000010,
    S_SCAN_CHK = 10'b0000000100,
    S_ACC_RD   = 10'b0000001000,
    S_ACC_ADD  = 10'b0000010000,
    S_VAR_MUL  = 10'b0000100000,
    S_VAR_LIM  = 10'b0001000000,
    S_VAR_CMP  = 10'b0010000000,
    S_DONE     = 10'b0100000000,
    S_OUT      = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic       store;
    logic       query;
    logic       rd;
    logic       idx_inc;
    logic       set_first;
    logic       set_last;
    logic       acc_add;
    logic       set_n;
    logic       mul;
    logic       lim;
    logic       cmp;
    logic       commit;
    logic       set_result;
    logic [1:0] result;
    logic       push;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic count_zero;
    logic t_lt_q;
    logic t_old;
    logic have_first;
    logic idx_zero;
    logic idx_end;
    logic idx_eq_last;
    logic axis_last;
    logic out_free;
  } flags_t;

endpackage
`default_nettype wire

[sv/isd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module isd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            command,
  output logic                 in_stall,
  input  wire isd_pkg::flags_t flags,
  output isd_pkg::cmd_t        cmd
);
  import isd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (command == CMD_SAMPLE) begin
            cmd.store = 1'b1;
          end else begin
            cmd.query = 1'b1;
            if (!flags.enable) begin
              cmd.set_result = 1'b1;
              cmd.result     = ST_MOVING;
              state_next     = S_OUT;
            end else if (flags.count_zero) begin
              cmd.set_result = 1'b1;
              cmd.result     = ST_UNKNOWN;
              state_next     = S_OUT;
            end else begin
              state_next = S_SCAN_RD;
            end
          end
        end
      end
      S_SCAN_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!flags.have_first && flags.t_lt_q && flags.idx_zero) begin
          // newest sample older than the query
          cmd.set_result = 1'b1;
          cmd.result     = ST_UNKNOWN;
          state_next     = S_OUT;
        end else if (flags.have_first && flags.t_old) begin
          cmd.set_last = 1'b1;
          state_next   = S_ACC_RD;
        end else begin
          cmd.set_first = !flags.have_first && flags.t_lt_q;
          if (flags.idx_end) begin
            cmd.set_result = 1'b1;
            cmd.result     = ST_UNKNOWN;
            state_next     = S_OUT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_SCAN_RD;
          end
        end
      end
      S_ACC_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_ACC_ADD;
      end
      S_ACC_ADD: begin
        cmd.acc_add = 1'b1;
        if (flags.idx_eq_last) begin
          cmd.set_n  = 1'b1;
          state_next = S_VAR_MUL;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_ACC_RD;
        end
      end
      S_VAR_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_VAR_LIM;
      end
      S_VAR_LIM: begin
        cmd.lim    = 1'b1;
        state_next = S_VAR_CMP;
      end
      S_VAR_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = flags.axis_last ? S_DONE : S_VAR_MUL;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (flags.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory read always precedes its check
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN_CHK |-> $past(state) == S_SCAN_RD)
    else $error("scan check without read");
  a_acc_order: assert property (@(posedge clk) disable iff (rst)
    state == S_ACC_ADD |-> $past(state) == S_ACC_RD)
    else $error("accumulate without read");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> flags.out_free && state == S_OUT)
    else $error("result pushed over a waiting item");

endmodule
`default_nettype wire

[sv/isd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module isd_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire isd_pkg::cmd_t                       cmd,
  output isd_pkg::flags_t                          flags,
  input  wire logic [isd_pkg::TIME_W-1:0]          stamp,
  input  wire logic signed [isd_pkg::SAMPLE_W-1:0] gyro_x,
  input  wire logic signed [isd_pkg::SAMPLE_W-1:0] gyro_y,
  input  wire logic signed [isd_pkg::SAMPLE_W-1:0] gyro_z,
  input  wire logic signed [isd_pkg::SAMPLE_W-1:0] accel_x,
  input  wire logic signed [isd_pkg::SAMPLE_W-1:0] accel_y,
  input  wire logic signed [isd_pkg::SAMPLE_W-1:0] accel_z,
  input  wire logic                                cfg_valid,
  input  wire logic [isd_pkg::IDX_W-1:0]           cfg_index,
  input  wire logic [isd_pkg::CFG_W-1:0]           cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               motion_status,
  output logic [isd_pkg::CNT_W-1:0]                used_count
);
  import isd_pkg::*;

  localparam int ENTRY_W = TIME_W + AXES * SAMPLE_W;

  // configuration registers
  logic              enable;
  logic [TIME_W-1:0] window;
  logic [LIM_W-1:0]  gyro_lim;
  logic [LIM_W-1:0]  acc_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b1;
      window   <= TIME_W'(500000);
      gyro_lim <= LIM_W'(100);
      acc_lim  <= LIM_W'(100);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE: enable   <= cfg_data[0];
        REG_WINDOW: window   <= cfg_data[TIME_W-1:0];
        REG_GYRO:   gyro_lim <= cfg_data[LIM_W-1:0];
        REG_ACC:    acc_lim  <= cfg_data[LIM_W-1:0];
        default:    ;
      endcase
    end
  end

  // ring control
  logic [PTR_W-1:0] ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx, first, last, n;
  logic             have_first;
  logic [TIME_W-1:0] qstamp;
  logic              do_store;

  assign do_store = cmd.store && enable;

  // sample memory
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [PTR_W-1:0]   wr_addr, rd_addr;

  assign wr_addr = ptr + PTR_W'(1);
  assign rd_addr = ptr - idx[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (do_store)
      mem[wr_addr] <= {stamp, accel_z, accel_y, accel_x, gyro_z, gyro_y, gyro_x};
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_data <= mem[rd_addr];
  end

  logic [TIME_W-1:0] rd_stamp;
  logic [TIME_W-1:0] age;
  assign rd_stamp = rd_data[ENTRY_W-1 -: TIME_W];
  assign age      = qstamp - rd_stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      count      <= '0;
      have_first <= 1'b0;
    end else begin
      if (do_store) begin
        ptr <= wr_addr;
        if (count != CNT_W'(DEPTH)) count <= count + CNT_W'(1);
      end
      if (cmd.commit) count <= last;
      if (cmd.query) have_first <= 1'b0;
      if (cmd.set_first) have_first <= 1'b1;
    end
  end

  // scan and window indexes
  always_ff @(posedge clk) begin
    if (cmd.query) begin
      qstamp <= stamp;
      idx    <= '0;
    end
    if (cmd.set_first) first <= idx - CNT_W'(1);
    if (cmd.set_last) begin
      last <= idx;
      idx  <= first;
    end else if (cmd.idx_inc) begin
      idx <= idx + CNT_W'(1);
    end
    if (cmd.set_n) n <= idx - first + CNT_W'(1);
  end

  // full-width squares of the entry just read
  logic signed [2*SAMPLE_W-1:0] sq_terms [AXES];

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      sq_terms[k] = (2*SAMPLE_W)'($signed(rd_data[k*SAMPLE_W +: SAMPLE_W])) *
                    (2*SAMPLE_W)'($signed(rd_data[k*SAMPLE_W +: SAMPLE_W]));
    end
  end

  // per-axis accumulators
  logic signed [SUM_W-1:0] sums [AXES];
  logic [SQ_W-1:0]         sqs  [AXES];

  always_ff @(posedge clk) begin
    for (int k = 0; k < AXES; k++) begin
      if (cmd.set_last) begin
        sums[k] <= '0;
        sqs[k]  <= '0;
      end else if (cmd.acc_add) begin
        sums[k] <= sums[k] + SUM_W'($signed(rd_data[k*SAMPLE_W +: SAMPLE_W]));
        sqs[k]  <= sqs[k] + SQ_W'($unsigned(sq_terms[k]));
      end
    end
  end

  // variance test: n*sq - sum^2 < limit*n^2, one axis at a time
  logic [2:0]              axis;
  logic                    still;
  logic [VAR_W-1:0]        p1, p2, d, c;
  logic [2*CNT_W-1:0]      nn;
  logic signed [SUM_W-1:0] sel_sum;
  logic [SUM_W-1:0]        mag;
  logic [LIM_W-1:0]        lim;

  assign sel_sum = sums[axis];
  assign mag     = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
  assign lim     = (axis < 3'd3) ? gyro_lim : acc_lim;

  always_ff @(posedge clk) begin
    if (cmd.set_n) begin
      axis  <= '0;
      still <= 1'b1;
    end
    if (cmd.mul) begin
      p1 <= VAR_W'(n * sqs[axis]);
      p2 <= VAR_W'(mag * mag);
      nn <= n * n;
    end
    if (cmd.lim) begin
      d <= p1 - p2;
      c <= VAR_W'(lim * nn);
    end
    if (cmd.cmp) begin
      if (!(d < c)) still <= 1'b0;
      axis <= axis + 3'd1;
    end
  end

  // result register
  logic [1:0]       res_status;
  logic [CNT_W-1:0] res_used;

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      res_status <= cmd.result;
      res_used   <= '0;
    end else if (cmd.commit) begin
      res_status <= still ? ST_STATIONARY : ST_MOVING;
      res_used   <= n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      motion_status <= res_status;
      used_count    <= res_used;
    end
  end

  // status back to the controller
  always_comb begin
    flags.enable      = enable;
    flags.count_zero  = (count == '0);
    flags.t_lt_q      = rd_stamp < qstamp;
    flags.t_old       = (rd_stamp < qstamp) && (age > window);
    flags.have_first  = have_first;
    flags.idx_zero    = (idx == '0);
    flags.idx_end     = (idx + CNT_W'(1) == count);
    flags.idx_eq_last = (idx == last);
    flags.axis_last   = (axis == 3'(AXES - 1));
    flags.out_free    = !out_valid || !out_stall;
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> motion_status != 2'd3)
    else $error("bad status code");
  a_commit_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> count <= $past(count))
    else $error("commit grew the store");

endmodule
`default_nettype wire

[sv/imu_stationary_detector_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Stationary detector over a 256-entry ring of timestamped six-axis samples.
// A sample item is stored, if enabled, while the controller stays idle. A
// query item walks the ring from the newest entry, with a read and a check
// state per entry, up to the window end, then sums the window with a read
// and an add state per entry and runs multiply, limit and compare states per
// axis for the variance test. A query may be answered without a scan, or be
// found unknown during the scan. A stalled output holds back the next result
// push while the last result still waits. The sample memory has a single
// read port. One result item per query, none per sample; the result waits
// in an output register while the next item is taken. Configuration:
// cfg_ready is always high.
module imu_stationary_detector_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                command,
  input  wire logic [isd_pkg::TIME_W-1:0]          stamp,
  input  wire logic signed [isd_pkg::SAMPLE_W-1:0] gyro_x,
  input  wire logic signed [isd_pkg::SAMPLE_W-1:0] gyro_y,
  input  wire logic signed [isd_pkg::SAMPLE_W-1:0] gyro_z,
  input  wire logic signed [isd_pkg::SAMPLE_W-1:0] accel_x,
  input  wire logic signed [isd_pkg::SAMPLE_W-1:0] accel_y,
  input  wire logic signed [isd_pkg::SAMPLE_W-1:0] accel_z,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               motion_status,
  output logic [isd_pkg::CNT_W-1:0]                used_count,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [isd_pkg::IDX_W-1:0]           cfg_index,
  input  wire logic [isd_pkg::CFG_W-1:0]           cfg_data
);
  import isd_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  assign cfg_ready = 1'b1;

  isd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .flags    (flags),
    .cmd      (cmd)
  );

  isd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .flags         (flags),
    .stamp         (stamp),
    .gyro_x        (gyro_x),
    .gyro_y        (gyro_y),
    .gyro_z        (gyro_z),
    .accel_x       (accel_x),
    .accel_y       (accel_y),
    .accel_z       (accel_z),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .motion_status (motion_status),
    .used_count    (used_count)
  );

endmodule
`default_nettype wire

[tb/imu_stationary_detector_unit_tb.sv]
`timescale 1ns / 1ps
module imu_stationary_detector_unit_tb;
  import isd_pkg::*;

  localparam int HOLD_LIMIT = 200000;
  localparam int SETTLE     = 1200;

  typedef struct packed {
    logic                 cmd;
    logic [TIME_W-1:0]    ts;
    logic [6*SAMPLE_W-1:0] ax;
  } imu_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = 1'b0;
  logic [TIME_W-1:0] stamp = '0;
  logic signed [SAMPLE_W-1:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic signed [SAMPLE_W-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] motion_status;
  logic [CNT_W-1:0] used_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  imu_stationary_detector_unit dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [TIME_W-1:0]         ring_ts [DEPTH];
  logic signed [SAMPLE_W-1:0] ring_ax [DEPTH][AXES];
  int unsigned newest, filled;
  logic        en_m;
  logic [31:0] win_m, glim_m, alim_m;

  imu_item_t pending_items[$];
  verdict_t  verdicts_due[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  driving = 1'b0;
  int  in_gap = 0, out_gap = 0;

  function automatic int unsigned slot(int unsigned age);
    return (newest + DEPTH - (age % DEPTH)) % DEPTH;
  endfunction

  // variance test: n*sq - sum^2 < limit*n^2
  function automatic bit axis_still(longint n, longint sum, longint sq, logic [31:0] lim);
    logic [127:0] lhs, rhs;
    lhs = 128'(n) * 128'(sq) - 128'(sum * sum);
    rhs = 128'(lim) * 128'(n * n);
    return lhs < rhs;
  endfunction

  function automatic void predict_motion(imu_item_t it);
    verdict_t v;
    int unsigned first, last, n;
    bit have_first, have_last, still;
    logic [TIME_W-1:0] t;
    longint s [AXES];
    longint q [AXES];
    if (it.cmd == CMD_SAMPLE) begin
      if (en_m) begin
        newest = (newest + 1) % DEPTH;
        ring_ts[newest] = it.ts;
        for (int k = 0; k < AXES; k++) ring_ax[newest][k] = it.ax[k*SAMPLE_W +: SAMPLE_W];
        if (filled < DEPTH) filled++;
      end
      return;
    end
    v.count = '0;
    if (!en_m) begin
      v.status = ST_MOVING; verdicts_due.push_back(v); return;
    end
    if (filled == 0 || ring_ts[slot(0)] < it.ts) begin
      v.status = ST_UNKNOWN; verdicts_due.push_back(v); return;
    end
    have_first = 0; have_last = 0; first = 0; last = 0;
    for (int unsigned i = 0; i < filled; i++) begin
      t = ring_ts[slot(i)];
      if (!have_first) begin
        if (t < it.ts) begin have_first = 1; first = i - 1; end
        continue;
      end
      if (t < it.ts && (it.ts - t) > win_m) begin have_last = 1; last = i; break; end
    end
    if (!have_first || !have_last) begin
      v.status = ST_UNKNOWN; verdicts_due.push_back(v); return;
    end
    for (int k = 0; k < AXES; k++) begin s[k] = 0; q[k] = 0; end
    for (int unsigned i = first; i <= last; i++)
      for (int k = 0; k < AXES; k++) begin
        s[k] += ring_ax[slot(i)][k];
        q[k] += longint'(ring_ax[slot(i)][k]) * ring_ax[slot(i)][k];
      end
    n = last - first + 1;
    still = 1;
    for (int k = 0; k < AXES; k++)
      if (!axis_still(n, s[k], q[k], k < 3 ? glim_m : alim_m)) still = 0;
    filled = last;
    v.status = still ? ST_STATIONARY : ST_MOVING;
    v.count  = n[CNT_W-1:0];
    verdicts_due.push_back(v);
  endfunction

  // item driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_motion({command, stamp, accel_z, accel_y, accel_x, gyro_z, gyro_y, gyro_x});
      end
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_valid <= 1'b0; in_gap <= in_gap - 1;
      end else if (driving && pending_items.size() > 0) begin
        imu_item_t it;
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        command <= it.cmd; stamp <= it.ts;
        {accel_z, accel_y, accel_x, gyro_z, gyro_y, gyro_x} <= it.ax;
        if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %0d/%0d", motion_status, used_count);
        end else begin
          verdict_t e;
          e = verdicts_due.pop_front();
          if (e.status !== motion_status || e.count !== used_count) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: status exp %0d got %0d, count exp %0d got %0d",
                       e.status, motion_status, e.count, used_count);
          end
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1; out_gap <= out_gap - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1; out_gap <= $urandom_range(0, 5);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HOLD_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENABLE: en_m   = val[0];
      REG_WINDOW: win_m  = val;
      REG_GYRO:   glim_m = val;
      default:    alim_m = val;
    endcase
  endtask

  // push items and let them drain; checks sit between edges
  task automatic drain();
    driving = 1'b1;
    do @(negedge clk); while (pending_items.size() > 0 || in_valid);
    driving = 1'b0;
    while (verdicts_due.size() > 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic imu_item_t make_sample(logic [31:0] ts, int spread);
    imu_item_t it;
    it.cmd = CMD_SAMPLE; it.ts = ts;
    for (int k = 0; k < AXES; k++)
      it.ax[k*SAMPLE_W +: SAMPLE_W] = (spread >= 32768) ? 16'($urandom)
                                     : 16'($signed($urandom_range(0, 2*spread)) - spread);
    return it;
  endfunction

  function automatic imu_item_t make_query(logic [31:0] ts);
    imu_item_t it;
    it.cmd = CMD_QUERY; it.ts = ts; it.ax = {6*SAMPLE_W{1'b1}} & 96'($urandom);
    return it;
  endfunction

  // one well-formed burst: rising stamps then a query from its middle to one step past its end
  task automatic queue_burst(int len, int step, int spread);
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < len; i++) pending_items.push_back(make_sample(base + i*step, spread));
    pending_items.push_back(make_query(base + $urandom_range(len/2, len) * step));
  endtask

  initial begin
    en_m = 1; win_m = 500000; glim_m = 100; alim_m = 100;
    newest = 0; filled = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, extremes, tiny window, disable
    write_reg(REG_WINDOW, 32'd5);
    pending_items.push_back(make_query(32'd0));
    for (int i = 0; i < 6; i++) begin
      imu_item_t s;
      s = make_sample(32'd100 + 10*i, 0);
      s.ax = (i % 2) ? {6{16'sh7fff}} : {6{16'sh8000}};
      pending_items.push_back(s);
    end
    pending_items.push_back(make_query(32'd200));
    pending_items.push_back(make_query(32'd150));
    pending_items.push_back(make_query(32'd145));
    pending_items.push_back(make_query(32'd105));
    pending_items.push_back(make_sample(32'hffff_ffff, 0));
    pending_items.push_back(make_query(32'hffff_ffff));
    drain();
    write_reg(REG_GYRO, 32'hffff_ffff);
    write_reg(REG_ACC, 32'hffff_ffff);
    queue_burst(12, 3, 32767);
    queue_burst(8, 1, 0);
    drain();
    write_reg(REG_GYRO, 32'd0);
    queue_burst(10, 2, 0);
    drain();
    write_reg(REG_ENABLE, 32'd0);
    pending_items.push_back(make_sample(32'd7, 5));
    pending_items.push_back(make_query(32'd7));
    drain();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_WINDOW, 32'hffff_ffff);
    queue_burst(6, 4, 10);
    drain();

    // random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_WINDOW, (ph == 7) ? 32'd0 : $urandom_range(1, 60));
      write_reg(REG_GYRO, (ph % 3 == 0) ? $urandom : $urandom_range(0, 2000));
      write_reg(REG_ACC, (ph % 3 == 1) ? $urandom : $urandom_range(0, 2000));
      write_reg(REG_ENABLE, (ph == 5) ? 32'd0 : 32'd1);
      quiet = (ph == 7);
      while (pending_items.size() < 230) begin
        if ($urandom_range(0, 9) < 8)
          queue_burst($urandom_range(2, 30), $urandom_range(1, 8),
                      $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(0, 40));
        else if ($urandom_range(0, 1))
          pending_items.push_back(make_sample($urandom, 32767));
        else
          pending_items.push_back(make_query($urandom));
      end
      drain();
    end

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
